@@ sv/mcfp_pkg.sv @@
// Shared types, byte codes and helpers for the motor command frame parser.
package mcfp_pkg;

	localparam int LINE_MAX_DEF = 32;
	localparam int BYTE_W       = 8;
	localparam int TARGET_W     = 16;
	localparam int CHAR_INDEX_W = 6;

	localparam logic [BYTE_W-1:0] CH_X  = 8'h58;
	localparam logic [BYTE_W-1:0] CH_Y  = 8'h59;
	localparam logic [BYTE_W-1:0] CH_C  = 8'h43;
	localparam logic [BYTE_W-1:0] CH_E  = 8'h45;
	localparam logic [BYTE_W-1:0] CH_L  = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_R  = 8'h52;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_UC_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UC_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	typedef enum logic [2:0] {
		KIND_STOP  = 3'd0,
		KIND_LEFT  = 3'd1,
		KIND_RIGHT = 3'd2,
		KIND_CHAR  = 3'd3,
		KIND_EMPTY = 3'd4
	} kind_t;

	typedef struct packed {
		logic  accept;
		logic  clr_fill;
		logic  inc_fill;
		logic  store_frame;
		logic  store_line;
		logic  clr_rd;
		logic  inc_rd;
		logic  rd_en;
		logic  load_res;
		logic  load_char;
		kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic is_x;
		logic is_y;
		logic is_c;
		logic is_term;
		logic fill_is3;
		logic line_full;
		logic fill_zero;
		logic rd_last;
		logic out_free;
		logic op_stop;
		logic op_left;
		logic op_right;
	} dp_stat_t;

	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

@@ sv/mcfp_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mcfp_dp.sv @@
// Datapath: byte classification, counters, frame bytes, line store and result register.
module mcfp_dp
	import mcfp_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [BYTE_W-1:0]       rx_byte,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              kind,
	output logic [TARGET_W-1:0]     target,
	output logic [BYTE_W-1:0]       line_char,
	output logic [CHAR_INDEX_W-1:0] char_index,
	output logic                    last
);

	localparam int FILL_W = $clog2(LINE_MAX);

	logic [FILL_W-1:0]       fill_q;
	logic [FILL_W-1:0]       rd_idx_q;
	logic [BYTE_W-1:0]       op_q;
	logic [BYTE_W-1:0]       tgt_hi_q;
	logic [BYTE_W-1:0]       tgt_lo_q;
	logic                    out_valid_q;
	kind_t                   kind_q;
	logic [TARGET_W-1:0]     target_q;
	logic [BYTE_W-1:0]       line_char_q;
	logic [CHAR_INDEX_W-1:0] char_index_q;
	logic                    last_q;
	logic [BYTE_W-1:0]       ram_rdata;

	mcfp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_MAX)
	) u_line_store (
		.clk  (clk),
		.we   (cmd.store_line),
		.waddr(fill_q),
		.wdata(rx_byte),
		.re   (cmd.rd_en),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.is_x      = (rx_byte == CH_X);
		stat.is_y      = (rx_byte == CH_Y);
		stat.is_c      = (rx_byte == CH_C);
		stat.is_term   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
		stat.fill_is3  = (fill_q == FILL_W'(3));
		stat.line_full = (fill_q >= FILL_W'(LINE_MAX - 1));
		stat.fill_zero = (fill_q == '0);
		stat.rd_last   = (rd_idx_q == (fill_q - FILL_W'(1)));
		stat.out_free  = !out_valid_q || out_ready;
		stat.op_stop   = (op_q == CH_E);
		stat.op_left   = (op_q == CH_L);
		stat.op_right  = (op_q == CH_R);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.inc_fill) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.clr_rd) begin
				rd_idx_q <= '0;
			end else if (cmd.inc_rd) begin
				rd_idx_q <= rd_idx_q + FILL_W'(1);
			end
			if (cmd.load_res || cmd.load_char) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_frame) begin
			case (fill_q[1:0])
				2'd0:    op_q     <= rx_byte;
				2'd1:    tgt_hi_q <= rx_byte;
				default: tgt_lo_q <= rx_byte;
			endcase
		end
		if (cmd.load_res) begin
			kind_q       <= cmd.res_kind;
			target_q     <= (cmd.res_kind == KIND_LEFT || cmd.res_kind == KIND_RIGHT) ?
			                {tgt_hi_q, tgt_lo_q} : '0;
			line_char_q  <= '0;
			char_index_q <= '0;
			last_q       <= 1'b1;
		end else if (cmd.load_char) begin
			kind_q       <= KIND_CHAR;
			target_q     <= '0;
			line_char_q  <= to_lower(ram_rdata);
			char_index_q <= CHAR_INDEX_W'(rd_idx_q);
			last_q       <= stat.rd_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign target     = target_q;
	assign line_char  = line_char_q;
	assign char_index = char_index_q;
	assign last       = last_q;

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_res && cmd.load_char))
		else $error("result and line byte loaded together");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_res || cmd.load_char) |-> stat.out_free)
		else $error("result register overwritten");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_line |-> !stat.line_full)
		else $error("line store written past its limit");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_CHAR) |->
		(char_index_q < CHAR_INDEX_W'(LINE_MAX - 1)))
		else $error("line byte index out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_CHAR) |-> last_q)
		else $error("single result without last");

endmodule

@@ sv/mcfp_ctrl.sv @@
// Controller: start-byte hunt, frame and line collection, line drain sequencing.
module mcfp_ctrl
	import mcfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHORT,
		S_LINE,
		S_RD,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		in_ready = (state_q == S_IDLE || state_q == S_SHORT || state_q == S_LINE) &&
		           stat.out_free;
		cmd          = '0;
		cmd.res_kind = KIND_STOP;
		cmd.accept   = in_valid && in_ready;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					cmd.clr_fill = 1'b1;
					if (stat.is_x) begin
						state_d = S_SHORT;
					end else if (stat.is_y) begin
						state_d = S_LINE;
					end
				end
			end
			S_SHORT: begin
				if (cmd.accept) begin
					if (stat.fill_is3) begin
						cmd.clr_fill = 1'b1;
						state_d      = S_IDLE;
						if (stat.is_c) begin
							if (stat.op_stop) begin
								cmd.load_res = 1'b1;
								cmd.res_kind = KIND_STOP;
							end else if (stat.op_left) begin
								cmd.load_res = 1'b1;
								cmd.res_kind = KIND_LEFT;
							end else if (stat.op_right) begin
								cmd.load_res = 1'b1;
								cmd.res_kind = KIND_RIGHT;
							end
						end
					end else begin
						cmd.store_frame = 1'b1;
						cmd.inc_fill    = 1'b1;
					end
				end
			end
			S_LINE: begin
				if (cmd.accept) begin
					if (stat.line_full) begin
						cmd.clr_fill = 1'b1;
						state_d      = S_IDLE;
					end else if (stat.is_term) begin
						if (stat.fill_zero) begin
							cmd.load_res = 1'b1;
							cmd.res_kind = KIND_EMPTY;
							state_d      = S_IDLE;
						end else begin
							cmd.clr_rd = 1'b1;
							state_d    = S_RD;
						end
					end else begin
						cmd.store_line = 1'b1;
						cmd.inc_fill   = 1'b1;
					end
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.load_char = 1'b1;
					if (stat.rd_last) begin
						cmd.clr_fill = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.inc_rd = 1'b1;
						state_d    = S_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_LOAD) |-> !in_ready)
		else $error("input taken during line drain");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (state_q == S_LOAD))
		else $error("line store read not followed by load");

	a_drain_from_line: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_RD) && $past(state_q == S_LINE) |-> $past(stat.is_term))
		else $error("drain started without terminator");

endmodule

@@ sv/motor_command_frame_parser.sv @@
// Top level of the motor command frame parser.
// Takes one received byte per item and returns command results. A byte is taken when offered
// while a start byte is hunted or a frame or line is collected; 'X' opens a frame of four more
// bytes whose last byte must be 'C', 'Y' opens a text line ended by CR or LF. A terminator after a
// non-empty line starts a drain of the line store in which each stored byte is read through the
// store's registered read port and then loaded into the result register, a load waiting until
// that register is free; no byte is taken during the drain. The result register holds one item; a
// new byte is taken only when that register is empty or being emptied in the same cycle.
module motor_command_frame_parser
	import mcfp_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [BYTE_W-1:0]       rx_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              kind,
	output logic [TARGET_W-1:0]     target,
	output logic [BYTE_W-1:0]       line_char,
	output logic [CHAR_INDEX_W-1:0] char_index,
	output logic                    last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mcfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	mcfp_dp #(
		.LINE_MAX(LINE_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.target    (target),
		.line_char (line_char),
		.char_index(char_index),
		.last      (last)
	);

endmodule

@@ tb/motor_command_frame_parser_tb.sv @@
// Self-checking testbench for the motor command frame parser against a byte-level predictor.
module motor_command_frame_parser_tb;
	import mcfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN     = LINE_MAX_DEF;
	localparam int RANDOM_BYTES = 400;
	localparam int TAIL_BYTES   = 60;
	localparam int DRAIN_CYCLES = 2 * LINE_LEN + 16;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FRAME = 2'd1,
		PH_LINE  = 2'd2
	} parse_phase_t;

	typedef struct {
		kind_t                   kind;
		logic [TARGET_W-1:0]     target;
		logic [BYTE_W-1:0]       line_char;
		logic [CHAR_INDEX_W-1:0] char_index;
		logic                    last;
	} motor_cmd_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [BYTE_W-1:0]       rx_byte = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2:0]              kind;
	logic [TARGET_W-1:0]     target;
	logic [BYTE_W-1:0]       line_char;
	logic [CHAR_INDEX_W-1:0] char_index;
	logic                    last;

	logic [BYTE_W-1:0] rx_stream [$];
	motor_cmd_t        decoded_cmds [$];
	motor_cmd_t        oldest_cmd;

	parse_phase_t      parse_phase = PH_IDLE;
	int                fill = 0;
	logic [BYTE_W-1:0] line_buf [LINE_LEN];

	int bytes_total = 0;
	int bytes_taken = 0;
	int errors = 0;
	int gap_left = 0;
	int stall_left = 0;

	motor_command_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.target     (target),
		.line_char  (line_char),
		.char_index (char_index),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic motor_cmd_t pack_cmd(input kind_t k, input logic [TARGET_W-1:0] t,
			input logic [BYTE_W-1:0] ch, input logic [CHAR_INDEX_W-1:0] idx, input logic l);
		motor_cmd_t r;
		r.kind = k;
		r.target = t;
		r.line_char = ch;
		r.char_index = idx;
		r.last = l;
		return r;
	endfunction

	task automatic decode_rx_byte(input logic [BYTE_W-1:0] c);
		int pos;
		logic [BYTE_W-1:0] ch;
		case (parse_phase)
			PH_FRAME: begin
				if (fill < 4) begin
					line_buf[fill] = c;
				end
				fill++;
				if (fill >= 4) begin
					parse_phase = PH_IDLE;
					fill = 0;
					if (line_buf[3] == CH_C) begin
						if (line_buf[0] == CH_E) begin
							decoded_cmds.push_back(pack_cmd(KIND_STOP, '0, '0, '0, 1'b1));
						end else if (line_buf[0] == CH_L) begin
							decoded_cmds.push_back(pack_cmd(KIND_LEFT, {line_buf[1], line_buf[2]},
								'0, '0, 1'b1));
						end else if (line_buf[0] == CH_R) begin
							decoded_cmds.push_back(pack_cmd(KIND_RIGHT, {line_buf[1], line_buf[2]},
								'0, '0, 1'b1));
						end
					end
				end
			end
			PH_LINE: begin
				pos = fill;
				if (pos + 1 >= LINE_LEN) begin
					parse_phase = PH_IDLE;
					fill = 0;
				end else if (c == CH_CR || c == CH_LF) begin
					parse_phase = PH_IDLE;
					fill = 0;
					if (pos == 0) begin
						decoded_cmds.push_back(pack_cmd(KIND_EMPTY, '0, '0, '0, 1'b1));
					end else begin
						for (int i = 0; i < pos; i++) begin
							ch = line_buf[i];
							if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
								ch = ch + CASE_OFFSET;
							end
							decoded_cmds.push_back(pack_cmd(KIND_CHAR, '0, ch, i[CHAR_INDEX_W-1:0],
								i + 1 == pos));
						end
					end
				end else begin
					line_buf[pos] = c;
					fill = pos + 1;
				end
			end
			default: begin
				if (c == CH_X) begin
					parse_phase = PH_FRAME;
					fill = 0;
				end else if (c == CH_Y) begin
					parse_phase = PH_LINE;
					fill = 0;
				end else begin
					parse_phase = PH_IDLE;
				end
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic queue_frame(input logic [BYTE_W-1:0] op, input logic [BYTE_W-1:0] hi,
			input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] tail);
		rx_stream.push_back(CH_X);
		rx_stream.push_back(op);
		rx_stream.push_back(hi);
		rx_stream.push_back(lo);
		rx_stream.push_back(tail);
	endtask

	function automatic logic [BYTE_W-1:0] line_byte();
		logic [BYTE_W-1:0] b;
		do begin
			if ($urandom_range(0, 3) == 0) begin
				b = 8'($urandom_range(CH_UC_A, CH_UC_Z));
			end else begin
				b = 8'($urandom_range(0, 255));
			end
		end while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic queue_line(input int len, input logic [BYTE_W-1:0] term);
		rx_stream.push_back(CH_Y);
		for (int i = 0; i < len; i++) begin
			rx_stream.push_back(line_byte());
		end
		rx_stream.push_back(term);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_rx_byte(rx_byte);
				bytes_taken++;
			end
			if (in_valid && !in_ready) begin
				// hold the item until taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (rx_stream.size() > TAIL_BYTES && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else if (rx_stream.size() != 0) begin
				rx_byte <= rx_stream.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_cmds.size() == 0) begin
					$display("%0t: unexpected result kind %0d target %0h char %0h index %0d last %0b",
						$time, kind, target, line_char, char_index, last);
					errors++;
				end else begin
					oldest_cmd = decoded_cmds.pop_front();
					check_field("kind", 16'(oldest_cmd.kind), 16'(kind));
					check_field("target", oldest_cmd.target, target);
					check_field("line_char", 16'(oldest_cmd.line_char), 16'(line_char));
					check_field("char_index", 16'(oldest_cmd.char_index), 16'(char_index));
					check_field("last", 16'(oldest_cmd.last), 16'(last));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (rx_stream.size() > TAIL_BYTES && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int directed_bytes;
		int pick;
		queue_frame(CH_E, 8'h00, 8'h00, CH_C);
		queue_frame(CH_L, CH_X, CH_Y, CH_C);
		queue_frame(CH_R, 8'hFF, 8'hFF, CH_C);
		queue_frame(8'h51, CH_CR, CH_LF, CH_C);
		queue_frame(CH_L, 8'h12, 8'h34, 8'h00);
		rx_stream.push_back(8'hFF);
		rx_stream.push_back(CH_Y);
		rx_stream.push_back(CH_CR);
		rx_stream.push_back(CH_Y);
		rx_stream.push_back(8'h40);
		rx_stream.push_back(CH_UC_A);
		rx_stream.push_back(CH_UC_Z);
		rx_stream.push_back(8'h5B);
		rx_stream.push_back(8'h00);
		rx_stream.push_back(CH_LF);
		directed_bytes = rx_stream.size();

		while (rx_stream.size() < directed_bytes + RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				case ($urandom_range(0, 3))
					0: queue_frame(CH_E, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						($urandom_range(0, 9) != 0) ? CH_C : 8'($urandom_range(0, 255)));
					1: queue_frame(CH_L, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						($urandom_range(0, 9) != 0) ? CH_C : 8'($urandom_range(0, 255)));
					2: queue_frame(CH_R, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						($urandom_range(0, 9) != 0) ? CH_C : 8'($urandom_range(0, 255)));
					default: queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), CH_C);
				endcase
			end else if (pick < 80) begin
				queue_line(($urandom_range(0, 6) != 0) ? $urandom_range(0, 6)
					: $urandom_range(LINE_LEN - 4, LINE_LEN - 1),
					$urandom_range(0, 1) ? CH_CR : CH_LF);
			end else begin
				repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(0, 255)));
			end
		end
		bytes_total = rx_stream.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken != bytes_total) @(posedge clk);
		while (decoded_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
